// ===== rtl/weighted_live_fraction_top_macros.svh =====
// Assertion macros for the weighted live fraction block.
// Used by weighted_live_fraction_top; expects aclk and aresetn in scope.
`ifndef WEIGHTED_LIVE_FRACTION_TOP_MACROS_SVH
`define WEIGHTED_LIVE_FRACTION_TOP_MACROS_SVH

// Same-cycle implication.
`define WLF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wlf_pkg.sv =====
// Shared constants and types for the weighted live fraction block.
// No dependencies.
package wlf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;   // fraction incl. the 1.0 bit
    localparam int NUM_SLOTS = 3564;

    localparam int SLOT_W = 12;
    localparam int BUSY_W = 24;
    localparam int LUM_W  = 32;
    localparam int TURN_W = 32;
    localparam int WSUM_W = 61;
    localparam int LSUM_W = 44;
    localparam int PROD_W = LUM_W + QW;
    localparam int DIV_W  = (LSUM_W > TURN_W) ? LSUM_W : TURN_W;
    localparam int CNT_W  = $clog2(QW + 1);

    localparam logic [QW-1:0] ONE_FX = QW'(1) << FRAC_BITS;

    // Accumulator controls from the sequencer.
    typedef struct packed {
        logic load_prod;  // register lum * live
        logic prod_hi;    // 0: live_lo operand, 1: live_hi operand
        logic add_lo;     // add product into low sum
        logic add_hi;     // add product into high sum and lum into lum sum
        logic clear;      // zero all sums
    } acc_ctl_t;

endpackage

// ===== rtl/wlf_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, QW bits per run.
// Depends on wlf_pkg.
module wlf_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [wlf_pkg::DIV_W-1:0] rem_init,
    input  logic [wlf_pkg::QW-1:0]    low_init,
    input  logic [wlf_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [wlf_pkg::QW-1:0]    quotient
);
    import wlf_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg;
    logic [QW-1:0]    low_reg, q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DIV_W:0]   shifted;
    logic             ge;

    // one shared compare/subtract step
    always_comb begin
        shifted  = {rem_reg, low_reg[QW-1]};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? DIV_W'(shifted - {1'b0, div_reg}) : DIV_W'(shifted);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(QW);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            low_reg <= low_init;
            div_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/wlf_accum.sv =====
// Luminosity-weighted accumulators: one shared multiplier, saturating sums.
// Depends on wlf_pkg.
module wlf_accum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wlf_pkg::acc_ctl_t          ctl,
    input  logic [wlf_pkg::LUM_W-1:0]  lum,
    input  logic [wlf_pkg::QW-1:0]     live_lo,
    input  logic [wlf_pkg::QW-1:0]     live_hi,
    output logic [wlf_pkg::WSUM_W-1:0] wsum_lo,
    output logic [wlf_pkg::WSUM_W-1:0] wsum_hi,
    output logic [wlf_pkg::LSUM_W-1:0] lsum
);
    import wlf_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [WSUM_W-1:0] wsum_lo_reg, wsum_hi_reg;
    logic [LSUM_W-1:0] lsum_reg;
    logic [WSUM_W:0]   sum_lo, sum_hi;
    logic [LSUM_W:0]   sum_l;

    always_comb begin
        sum_lo = {1'b0, wsum_lo_reg} + (WSUM_W+1)'(prod_reg);
        sum_hi = {1'b0, wsum_hi_reg} + (WSUM_W+1)'(prod_reg);
        sum_l  = {1'b0, lsum_reg} + (LSUM_W+1)'(lum);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_reg <= lum * (ctl.prod_hi ? live_hi : live_lo);
        end
    end

    // carry out of the sum means saturate to all ones
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            wsum_lo_reg <= '0;
            wsum_hi_reg <= '0;
            lsum_reg    <= '0;
        end else begin
            if (ctl.add_lo) begin
                wsum_lo_reg <= sum_lo[WSUM_W] ? '1 : sum_lo[WSUM_W-1:0];
            end
            if (ctl.add_hi) begin
                wsum_hi_reg <= sum_hi[WSUM_W] ? '1 : sum_hi[WSUM_W-1:0];
                lsum_reg    <= sum_l[LSUM_W] ? '1 : sum_l[LSUM_W-1:0];
            end
        end
    end

    assign wsum_lo = wsum_lo_reg;
    assign wsum_hi = wsum_hi_reg;
    assign lsum    = lsum_reg;

endmodule

// ===== rtl/weighted_live_fraction_top.sv =====
// Top level of the weighted live fraction block: sequencer, config, output beat.
// Depends on wlf_pkg, wlf_divider, wlf_accum and the assertion macro header.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  s_      | in  | s_valid / s_ready      | slot, busy low/high, luminosity, last
//  m_      | out | m_valid / m_ready      | live low/high, average low/high, valid
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_turn_count (turn count register)
//
// Work per beat: two runs of the shared divider plus multiply/accumulate; a beat
//   marked last adds the two average divisions on the same divider.
// s_ready is high only while the sequencer is idle; one beat is in work at a time.
// A finished result waits in the output register; the next input beat is taken
//   while it waits, and the sequencer stalls before its own output only if the
//   previous result is still untaken.
// Reset (aresetn low, synchronous) clears the sums, the turn count and control.
// cfg_ready is always high; write the turn count only while the block is idle.
`include "weighted_live_fraction_top_macros.svh"

module weighted_live_fraction_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wlf_pkg::TURN_W-1:0] cfg_turn_count,
    // input beats
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wlf_pkg::SLOT_W-1:0] s_slot_number,
    input  logic [wlf_pkg::BUSY_W-1:0] s_busy_low,
    input  logic [wlf_pkg::BUSY_W-1:0] s_busy_high,
    input  logic [wlf_pkg::LUM_W-1:0]  s_luminosity,
    input  logic                       s_last_slot,
    // result beats
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wlf_pkg::QW-1:0]     m_live_low,
    output logic [wlf_pkg::QW-1:0]     m_live_high,
    output logic [wlf_pkg::QW-1:0]     m_average_low,
    output logic [wlf_pkg::QW-1:0]     m_average_high,
    output logic                       m_average_valid
);
    import wlf_pkg::*;

    localparam int CMP_W = (WSUM_W > LSUM_W + QW) ? WSUM_W : LSUM_W + QW;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_LIVE_LO = 10'b0000000010,
        ST_LIVE_HI = 10'b0000000100,
        ST_MUL_LO  = 10'b0000001000,
        ST_ACC_LO  = 10'b0000010000,
        ST_ACC_HI  = 10'b0000100000,
        ST_AVG_PRE = 10'b0001000000,
        ST_AVG_LO  = 10'b0010000000,
        ST_AVG_HI  = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // config register
    logic [TURN_W-1:0] turn_reg;

    // captured input beat
    logic [SLOT_W-1:0] slot_reg;
    logic [BUSY_W-1:0] busy_lo_reg, busy_hi_reg;
    logic [LUM_W-1:0]  lum_reg;
    logic              last_reg;

    // intermediate results
    logic [QW-1:0] live_lo_reg, live_lo_next;
    logic [QW-1:0] live_hi_reg, live_hi_next;
    logic [QW-1:0] avg_lo_reg, avg_lo_next;
    logic [QW-1:0] avg_hi_reg, avg_hi_next;
    logic          clamp_lo_reg, clamp_lo_next;
    logic          clamp_hi_reg, clamp_hi_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [QW-1:0] m_live_lo_reg, m_live_hi_reg, m_avg_lo_reg, m_avg_hi_reg;
    logic          m_avg_valid_reg;
    logic          out_load;

    // divider hookup
    logic              div_start, div_busy, div_done;
    logic [DIV_W-1:0]  div_rem_init, div_divisor;
    logic [QW-1:0]     div_low_init, div_q;

    // accumulator hookup
    acc_ctl_t          acc_ctl;
    logic [WSUM_W-1:0] wsum_lo, wsum_hi;
    logic [LSUM_W-1:0] lsum;

    logic              accept, in_range, include_slot;
    logic [TURN_W-1:0] diff_in, diff_hi;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign in_range     = {1'b0, slot_reg} < (SLOT_W+1)'(NUM_SLOTS);
    assign include_slot = in_range && (slot_reg != '0);

    assign diff_in = turn_reg - TURN_W'(s_busy_low);
    assign diff_hi = turn_reg - TURN_W'(busy_hi_reg);

    // zero turns -> 1.0, busy beyond turns -> 0, slot out of range -> 0
    function automatic logic [QW-1:0] live_pick(input logic [TURN_W-1:0] turn,
                                                input logic [BUSY_W-1:0] busy,
                                                input logic              ok,
                                                input logic [QW-1:0]     q);
        logic [QW-1:0] res;
        if (!ok) begin
            res = '0;
        end else if (turn == '0) begin
            res = ONE_FX;
        end else if (TURN_W'(busy) > turn) begin
            res = '0;
        end else begin
            res = q;
        end
        return res;
    endfunction

    // clamp or quotient above 1.0 -> 1.0 (clamp also covers an empty luminosity sum)
    function automatic logic [QW-1:0] avg_pick(input logic          clamp,
                                               input logic [QW-1:0] q);
        logic [QW-1:0] res;
        if (clamp || (q > ONE_FX)) begin
            res = ONE_FX;
        end else begin
            res = q;
        end
        return res;
    endfunction

    always_comb begin
        state_next    = state_reg;
        live_lo_next  = live_lo_reg;
        live_hi_next  = live_hi_reg;
        avg_lo_next   = avg_lo_reg;
        avg_hi_next   = avg_hi_reg;
        clamp_lo_next = clamp_lo_reg;
        clamp_hi_next = clamp_hi_reg;
        div_start     = 1'b0;
        div_rem_init  = DIV_W'(diff_in >> 1);
        div_low_init  = {diff_in[0], FRAC_BITS'(0)};
        div_divisor   = DIV_W'(turn_reg);
        acc_ctl       = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // live_lo = ((turn - busy) << FRAC) / turn
                if (accept) begin
                    div_start  = 1'b1;
                    state_next = ST_LIVE_LO;
                end
            end
            ST_LIVE_LO: begin
                div_rem_init = DIV_W'(diff_hi >> 1);
                div_low_init = {diff_hi[0], FRAC_BITS'(0)};
                if (div_done) begin
                    live_lo_next = live_pick(turn_reg, busy_lo_reg, in_range, div_q);
                    div_start    = 1'b1;
                    state_next   = ST_LIVE_HI;
                end
            end
            ST_LIVE_HI: begin
                if (div_done) begin
                    live_hi_next = live_pick(turn_reg, busy_hi_reg, in_range, div_q);
                    state_next   = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                acc_ctl.load_prod = 1'b1;
                state_next        = ST_ACC_LO;
            end
            ST_ACC_LO: begin
                acc_ctl.add_lo    = include_slot;
                acc_ctl.load_prod = 1'b1;
                acc_ctl.prod_hi   = 1'b1;
                state_next        = ST_ACC_HI;
            end
            ST_ACC_HI: begin
                acc_ctl.add_hi = include_slot;
                state_next     = last_reg ? ST_AVG_PRE : ST_DONE;
            end
            ST_AVG_PRE: begin
                // quotient >= 2^QW is clamped without dividing
                clamp_lo_next = CMP_W'(wsum_lo) >= (CMP_W'(lsum) << QW);
                clamp_hi_next = CMP_W'(wsum_hi) >= (CMP_W'(lsum) << QW);
                div_rem_init  = DIV_W'(wsum_lo >> QW);
                div_low_init  = wsum_lo[QW-1:0];
                div_divisor   = DIV_W'(lsum);
                div_start     = 1'b1;
                state_next    = ST_AVG_LO;
            end
            ST_AVG_LO: begin
                div_rem_init = DIV_W'(wsum_hi >> QW);
                div_low_init = wsum_hi[QW-1:0];
                div_divisor  = DIV_W'(lsum);
                if (div_done) begin
                    avg_lo_next = avg_pick(clamp_lo_reg, div_q);
                    div_start   = 1'b1;
                    state_next  = ST_AVG_HI;
                end
            end
            ST_AVG_HI: begin
                if (div_done) begin
                    avg_hi_next   = avg_pick(clamp_hi_reg, div_q);
                    acc_ctl.clear = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            turn_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                turn_reg <= cfg_turn_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg    <= s_slot_number;
            busy_lo_reg <= s_busy_low;
            busy_hi_reg <= s_busy_high;
            lum_reg     <= s_luminosity;
            last_reg    <= s_last_slot;
        end
        live_lo_reg  <= live_lo_next;
        live_hi_reg  <= live_hi_next;
        avg_lo_reg   <= avg_lo_next;
        avg_hi_reg   <= avg_hi_next;
        clamp_lo_reg <= clamp_lo_next;
        clamp_hi_reg <= clamp_hi_next;
        if (out_load) begin
            m_live_lo_reg   <= live_lo_reg;
            m_live_hi_reg   <= live_hi_reg;
            m_avg_lo_reg    <= last_reg ? avg_lo_reg : '0;
            m_avg_hi_reg    <= last_reg ? avg_hi_reg : '0;
            m_avg_valid_reg <= last_reg;
        end
    end

    wlf_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    wlf_accum u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .lum     (lum_reg),
        .live_lo (live_lo_reg),
        .live_hi (live_hi_reg),
        .wsum_lo (wsum_lo),
        .wsum_hi (wsum_hi),
        .lsum    (lsum)
    );

    assign m_valid         = m_valid_reg;
    assign m_live_low      = m_live_lo_reg;
    assign m_live_high     = m_live_hi_reg;
    assign m_average_low   = m_avg_lo_reg;
    assign m_average_high  = m_avg_hi_reg;
    assign m_average_valid = m_avg_valid_reg;

    // divider is never restarted mid-run
    `WLF_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")

    // divider finishes only in a state that waits for it
    `WLF_ASSERT_NOW(a_div_done_state, div_done,
        (state_reg == ST_LIVE_LO) || (state_reg == ST_LIVE_HI) ||
        (state_reg == ST_AVG_LO) || (state_reg == ST_AVG_HI),
        "divider result arrived in a state not waiting for it")

    // fractions delivered never exceed 1.0
    `WLF_ASSERT_NOW(a_out_range, m_valid,
        (m_live_low <= ONE_FX) && (m_live_high <= ONE_FX) &&
        (m_average_low <= ONE_FX) && (m_average_high <= ONE_FX),
        "output fraction above 1.0")

    // sums are cleared after the averages are taken
    `WLF_ASSERT_NEXT(a_sum_clear, (state_reg == ST_AVG_HI) && div_done,
        (lsum == '0) && (wsum_lo == '0) && (wsum_hi == '0),
        "sums not cleared after last slot")

endmodule
